>>> src/tkspq_pkg.sv
`timescale 1ns / 1ps
// Package for the two-key sorted priority queue.
// Field widths, action and status codes, entry type and controller/datapath structs.
package tkspq_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;

  localparam int unsigned ACT_W    = 2;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_DRAIN   = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // One stored entry, ordered by {primary, secondary}
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] pri;
    logic [KEY_W-1:0] sec;
  } entry_t;

  typedef enum logic [1:0] {
    DP_NONE,
    DP_INSERT,
    DP_POP
  } dp_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESP,
    ST_DRAIN
  } ctrl_state_e;

  // Controller -> datapath
  typedef struct packed {
    dp_op_e  op;
    logic    res_load;
    status_e res_status;
    logic    res_last;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic one;
  } dp_sts_t;

endpackage

>>> src/tkspq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the queue: request and result channels.
// Depends on tkspq_pkg for field widths.
interface tkspq_in_if import tkspq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [TAG_W-1:0] entry_tag;
  logic [KEY_W-1:0] primary_key;
  logic [KEY_W-1:0] secondary_key;

  modport source (output valid, action, entry_tag, primary_key, secondary_key,
                  input ready);
  modport sink   (input valid, action, entry_tag, primary_key, secondary_key,
                  output ready);
endinterface

interface tkspq_out_if import tkspq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TAG_W-1:0]    out_tag;
  logic [KEY_W-1:0]    out_primary;
  logic [KEY_W-1:0]    out_secondary;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, out_tag, out_primary, out_secondary, status, last,
                  input ready);
  modport sink   (input valid, out_tag, out_primary, out_secondary, status, last,
                  output ready);
endinterface

>>> src/tkspq_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM of the sorted queue: decodes requests, sequences drains.
// Depends on tkspq_pkg; drives the datapath through dp_cmd_t.
module tkspq_ctrl import tkspq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ACT_W-1:0] in_action_i,
  input  logic             out_ready_i,
  input  dp_sts_t          sts_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output dp_cmd_t          cmd_o
);

  ctrl_state_e state_q, state_d;
  action_e     act;

  assign act = action_e'(in_action_i);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (act)
            ACT_ENQUEUE: state_d = ST_RESP;
            ACT_DEQUEUE: state_d = ST_RESP;
            ACT_DRAIN:   state_d = sts_i.empty ? ST_RESP : ST_DRAIN;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_RESP: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      ST_DRAIN: begin
        // queue empty means the last drained entry is the one being taken
        if (out_ready_i && sts_i.empty) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    cmd_o.op          = DP_NONE;
    cmd_o.res_load    = 1'b0;
    cmd_o.res_status  = STAT_OK;
    cmd_o.res_last    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (act)
            ACT_ENQUEUE: begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = sts_i.full ? STAT_FULL : STAT_OK;
              cmd_o.op         = sts_i.full ? DP_NONE : DP_INSERT;
            end
            ACT_DEQUEUE: begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = sts_i.empty ? STAT_EMPTY : STAT_OK;
              cmd_o.op         = sts_i.empty ? DP_NONE : DP_POP;
            end
            ACT_DRAIN: begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = sts_i.empty ? STAT_EMPTY : STAT_OK;
              cmd_o.op         = sts_i.empty ? DP_NONE : DP_POP;
              cmd_o.res_last   = sts_i.empty | sts_i.one;
            end
            default: begin
              cmd_o.res_load = 1'b0;
            end
          endcase
        end
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
      end
      ST_DRAIN: begin
        out_valid_o = 1'b1;
        // next head goes out as soon as the current one is taken
        if (out_ready_i && !sts_i.empty) begin
          cmd_o.op       = DP_POP;
          cmd_o.res_load = 1'b1;
          cmd_o.res_last = sts_i.one;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> src/tkspq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the sorted queue: shift-register cells with per-cell compare,
// entry count and result register. Depends on tkspq_pkg.
module tkspq_datapath import tkspq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [TAG_W-1:0] entry_tag_i,
  input  logic [KEY_W-1:0] primary_key_i,
  input  logic [KEY_W-1:0] secondary_key_i,
  output dp_sts_t          sts_o,
  output entry_t           res_o,
  output status_e          res_status_o,
  output logic             res_last_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t              cells_q [QUEUE_DEPTH];
  logic [CntW-1:0]     count_q, count_d;
  logic [QUEUE_DEPTH-1:0] geq;   // cell sorts at or after the new entry (empty = +inf)
  entry_t              new_entry;
  entry_t              res_q;
  status_e             res_status_q;
  logic                res_last_q;

  assign new_entry = '{tag: entry_tag_i, pri: primary_key_i, sec: secondary_key_i};

  // Parallel compare of every cell against the incoming key pair
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      geq[i] = (CntW'(i) >= count_q) ||
               ({cells_q[i].pri, cells_q[i].sec} >= {primary_key_i, secondary_key_i});
    end
  end

  // Cells: insert shifts the tail up one, pop shifts everything down one
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.op == DP_INSERT) begin
        if (g > 0 && geq[(g > 0) ? g - 1 : 0]) begin
          cells_q[g] <= cells_q[(g > 0) ? g - 1 : 0];
        end else if (geq[g]) begin
          cells_q[g] <= new_entry;
        end
      end else if (cmd_i.op == DP_POP) begin
        if (g < QUEUE_DEPTH - 1) begin
          cells_q[g] <= cells_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

  // Entry count
  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      DP_INSERT: count_d = count_q + CntW'(1);
      DP_POP:    count_d = count_q - CntW'(1);
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register: head entry on a pop, zero otherwise
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q        <= (cmd_i.op == DP_POP) ? cells_q[0] : '0;
      res_status_q <= cmd_i.res_status;
      res_last_q   <= cmd_i.res_last;
    end
  end

  assign sts_o.empty  = (count_q == '0);
  assign sts_o.full   = (count_q == CntW'(QUEUE_DEPTH));
  assign sts_o.one    = (count_q == CntW'(1));
  assign res_o        = res_q;
  assign res_status_o = res_status_q;
  assign res_last_o   = res_last_q;

endmodule

>>> src/two_key_sorted_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the two-key sorted priority queue: controller plus datapath.
// Depends on tkspq_pkg, tkspq_if, tkspq_ctrl and tkspq_datapath.
//
//   Channel | Modport | Transaction
//   in_i    | sink    | one request: enqueue, dequeue or drain
//   out_o   | source  | one result entry with status and last flag
//
// Enqueue and dequeue: the accept cycle also does the parallel insert or shift,
// then the registered result is shown on out_o until it is taken.
// A drain pops one head per result transaction, the first in the accept cycle.
// No request is accepted while a result is pending. Reset clears the entry count
// and the controller; cell contents need no reset. Stalls on out_o hold the result.
module two_key_sorted_priority_queue import tkspq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tkspq_in_if.sink   in_i,
  tkspq_out_if.source out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  entry_t  res;
  status_e res_status;
  logic    res_last;

  tkspq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  tkspq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .entry_tag_i     (in_i.entry_tag),
    .primary_key_i   (in_i.primary_key),
    .secondary_key_i (in_i.secondary_key),
    .sts_o           (sts),
    .res_o           (res),
    .res_status_o    (res_status),
    .res_last_o      (res_last)
  );

  assign out_o.out_tag       = res.tag;
  assign out_o.out_primary   = res.pri;
  assign out_o.out_secondary = res.sec;
  assign out_o.status        = res_status;
  assign out_o.last          = res_last;

`ifndef SYNTHESIS
  // Requests are blocked while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("request accepted while a result is pending");

  // Enqueue on a full queue reports full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.action == ACT_ENQUEUE && sts.full)
      |=> (out_o.valid && out_o.status == STAT_FULL))
    else $error("full enqueue not reported");

  // A drain result that is not the last is followed by another result
  a_drain_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last) |=> out_o.valid)
    else $error("drain stopped before its last entry");

  // After the last result the block is ready for a new request
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> in_i.ready)
    else $error("block not idle after last result");
`endif

endmodule

>>> bench/tb_two_key_sorted_priority_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-key sorted priority queue.
// Depends on tkspq_pkg, tkspq_if and the two_key_sorted_priority_queue top level.
module tb_two_key_sorted_priority_queue;
  import tkspq_pkg::*;

  localparam int unsigned QD          = 16;
  localparam int unsigned RAND_ITEMS  = 175;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned IDLE_PCT    = 34;
  localparam int unsigned DIR_ROWS    = 25;

  // Code 3 is not an action; the block drops it
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // One expected or observed result transaction
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] pri;
    logic [KEY_W-1:0] sec;
    status_e          status;
    logic             last;
  } result_t;

  // Directed row: request fields plus an optional typed-in status
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] pri;
    logic [KEY_W-1:0] sec;
    logic             typed;
    status_e          status;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tkspq_in_if  in_if ();
  tkspq_out_if out_if ();

  two_key_sorted_priority_queue #(
    .QUEUE_DEPTH(QD)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow of the sorted store
  entry_t      shadow_cells [QD];
  int unsigned shadow_len;

  result_t     pending_results [$];
  stim_row_t   dir_tbl [DIR_ROWS];

  int unsigned err_cnt     = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned n_requests  = 0;
  int unsigned n_checked   = 0;
  int unsigned n_full      = 0;
  int unsigned n_empty     = 0;
  int unsigned n_drains    = 0;
  bit          tx_steady   = 1'b0;
  bit          rx_steady   = 1'b0;

  // Clock: 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0:       return KEY_W'($urandom_range(3));
      1:       return KEY_W'(16'hFFFF - $urandom_range(3));
      default: return KEY_W'($urandom());
    endcase
  endfunction

  function automatic bit tx_idle();
    return !tx_steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic bit rx_idle();
    return !rx_steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Update the shadow store for one accepted request and queue its results
  function automatic void queue_apply(input logic [ACT_W-1:0] act,
                                      input logic [TAG_W-1:0] tag,
                                      input logic [KEY_W-1:0] pri,
                                      input logic [KEY_W-1:0] sec,
                                      input bit emit);
    int unsigned pos;
    bit          found;
    result_t     r;
    r = '{tag: '0, pri: '0, sec: '0, status: STAT_OK, last: 1'b1};
    case (act)
      ACT_ENQUEUE: begin
        if (shadow_len >= QD) begin
          r.status = STAT_FULL;
          if (emit) pending_results.push_back(r);
        end else begin
          // first cell not smaller than the new key pair; ties go ahead
          pos   = shadow_len;
          found = 1'b0;
          for (int unsigned i = 0; i < shadow_len; i++) begin
            if (!found && (shadow_cells[i].pri > pri ||
                (shadow_cells[i].pri == pri && shadow_cells[i].sec >= sec))) begin
              pos   = i;
              found = 1'b1;
            end
          end
          for (int unsigned i = shadow_len; i > pos; i--)
            shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[pos] = '{tag: tag, pri: pri, sec: sec};
          shadow_len++;
          if (emit) pending_results.push_back(r);
        end
      end
      ACT_DEQUEUE: begin
        if (shadow_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.tag = shadow_cells[0].tag;
          r.pri = shadow_cells[0].pri;
          r.sec = shadow_cells[0].sec;
          for (int unsigned i = 1; i < shadow_len; i++)
            shadow_cells[i-1] = shadow_cells[i];
          shadow_len--;
        end
        if (emit) pending_results.push_back(r);
      end
      ACT_DRAIN: begin
        if (shadow_len == 0) begin
          r.status = STAT_EMPTY;
          if (emit) pending_results.push_back(r);
        end else begin
          for (int unsigned i = 0; i < shadow_len; i++) begin
            r.tag  = shadow_cells[i].tag;
            r.pri  = shadow_cells[i].pri;
            r.sec  = shadow_cells[i].sec;
            r.last = (i + 1 == shadow_len);
            if (emit) pending_results.push_back(r);
          end
          shadow_len = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // Drive one request transaction and wait for it to be taken
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [TAG_W-1:0] tag,
                              input logic [KEY_W-1:0] pri, input logic [KEY_W-1:0] sec,
                              input bit typed, input status_e status);
    while (tx_idle()) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.action        <= act;
    in_if.entry_tag     <= tag;
    in_if.primary_key   <= pri;
    in_if.secondary_key <= sec;
    do @(posedge clk_i); while (!in_if.ready);
    queue_apply(act, tag, pri, sec, !typed);
    if (typed)
      pending_results.push_back('{tag: '0, pri: '0, sec: '0, status: status, last: 1'b1});
    n_requests++;
    if (act == ACT_DRAIN) n_drains++;
  endtask

  // Hold off the sender until every queued result has come back
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random backpressure and the scoreboard compare
  always @(posedge clk_i) begin : rx_check
    result_t got;
    result_t want;
    out_if.ready <= !rx_idle();
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{tag: out_if.out_tag, pri: out_if.out_primary, sec: out_if.out_secondary,
              status: status_e'(out_if.status), last: out_if.last};
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("[%0t] unexpected result: tag=%h pri=%h sec=%h status=%0d last=%b",
                   $realtime, got.tag, got.pri, got.sec, got.status, got.last);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.status == STAT_FULL)  n_full++;
        if (want.status == STAT_EMPTY) n_empty++;
        if (got.tag !== want.tag || got.pri !== want.pri || got.sec !== want.sec ||
            got.status !== want.status || got.last !== want.last) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN) begin
            $write("[%0t] mismatch: exp tag=%h pri=%h sec=%h status=%0d last=%b",
                   $realtime, want.tag, want.pri, want.sec, want.status, want.last);
            $display(" | got tag=%h pri=%h sec=%h status=%0d last=%b",
                     got.tag, got.pri, got.sec, got.status, got.last);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned rand_cnt;
    int unsigned run;
    int unsigned sel;
    bit          paused;

    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.action         <= ACT_ENQUEUE;
    in_if.entry_tag      <= '0;
    in_if.primary_key    <= '0;
    in_if.secondary_key  <= '0;
    shadow_len           = 0;
    rand_cnt             = 0;
    paused               = 1'b0;

    // Directed rows; typed-in status only for the obvious ones
    dir_tbl = '{
      '{ACT_DEQUEUE, 16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_EMPTY}, // dequeue on empty
      '{ACT_DRAIN,   16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_EMPTY}, // drain on empty
      '{ACT_ENQUEUE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'h0001, 16'h0000, 16'h0000, 1'b1, STAT_OK},    // tie at head
      '{ACT_ENQUEUE, 16'h0002, 16'hFFFF, 16'hFFFF, 1'b1, STAT_OK},    // tie at tail
      '{ACT_DEQUEUE, 16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK},
      '{ACT_UNUSED,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, STAT_OK},    // ignored code
      '{ACT_ENQUEUE, 16'hA5A5, 16'h8000, 16'h0001, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'h5A5A, 16'h7FFF, 16'hFFFF, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'h1234, 16'h8000, 16'h0000, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'h4321, 16'h8000, 16'h0001, 1'b1, STAT_OK},    // tie in middle
      '{ACT_ENQUEUE, 16'h0F0F, 16'h0001, 16'h8000, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'hF0F0, 16'hFFFE, 16'h0000, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'h00FF, 16'h0000, 16'hFFFF, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'hFF00, 16'h0000, 16'h0001, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'h3C3C, 16'h4000, 16'h4000, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'hC3C3, 16'h4000, 16'h3FFF, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'h6666, 16'hFFFF, 16'h0000, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'h9999, 16'h0001, 16'h0001, 1'b1, STAT_OK},
      '{ACT_ENQUEUE, 16'h7777, 16'h7FFF, 16'h0000, 1'b1, STAT_OK},    // sixteenth entry
      '{ACT_ENQUEUE, 16'hBEEF, 16'h0000, 16'h0000, 1'b1, STAT_FULL},  // dropped
      '{ACT_DRAIN,   16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK},
      '{ACT_ENQUEUE, 16'hCAFE, 16'h1111, 16'h2222, 1'b1, STAT_OK},
      '{ACT_DEQUEUE, 16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK}     // remove only entry
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    foreach (dir_tbl[i])
      send_request(dir_tbl[i].act, dir_tbl[i].tag, dir_tbl[i].pri, dir_tbl[i].sec,
                   dir_tbl[i].typed, dir_tbl[i].status);
    hold_until_drained();

    // Random part: enqueue bursts, dequeue runs, drains and some noise
    while (rand_cnt < RAND_ITEMS) begin
      tx_steady = (rand_cnt >= 40 && rand_cnt < 90);
      rx_steady = (rand_cnt >= 120 && rand_cnt < 170);
      if (!paused && rand_cnt >= 100) begin
        hold_until_drained();
        paused = 1'b1;
      end
      sel = $urandom_range(9);
      if (sel < 4) begin
        run = $urandom_range(1, 20);
        repeat (run)
          send_request(ACT_ENQUEUE, TAG_W'($urandom()), pick_key(), pick_key(), 1'b0,
                       STAT_OK);
        rand_cnt += run;
      end else if (sel < 7) begin
        run = $urandom_range(1, 6);
        repeat (run)
          send_request(ACT_DEQUEUE, TAG_W'($urandom()), KEY_W'($urandom()),
                       KEY_W'($urandom()), 1'b0, STAT_OK);
        rand_cnt += run;
      end else if (sel < 9) begin
        send_request(ACT_DRAIN, TAG_W'($urandom()), KEY_W'($urandom()),
                     KEY_W'($urandom()), 1'b0, STAT_OK);
        rand_cnt++;
      end else begin
        send_request(ACT_UNUSED, TAG_W'($urandom()), KEY_W'($urandom()),
                     KEY_W'($urandom()), 1'b0, STAT_OK);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // Let the last results and any trailing work settle
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      err_cnt++;
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("Summary: %0d requests (%0d drains), %0d results checked, %0d full, %0d empty",
             n_requests, n_drains, n_checked, n_full, n_empty);
    $display("Mismatches and stray results: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
